>>> rtl/ptl_pkg.sv
package ptl_pkg;

  // Default width table size
  localparam int unsigned TableDepth = 256;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [7:0] FirstSymbolRst  = 8'd32;
  localparam logic [5:0] FontHeightRst   = 6'd8;
  localparam logic [7:0] DisplayWidthRst = 8'd84;

  // Item actions
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_PLACE = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_SYMBOL  = 2'd0,
    CFG_FONT_HEIGHT   = 2'd1,
    CFG_DISPLAY_WIDTH = 2'd2
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] entry_index;
    logic [7:0] entry_width;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] draw_color;
    logic [7:0] symbol;
  } in_item_t;

  // Draw command word
  typedef struct packed {
    logic [7:0]  glyph_x;
    logic [7:0]  glyph_y;
    logic [15:0] glyph_offset;
    logic [7:0]  glyph_width;
    logic [7:0]  color_out;
    logic [7:0]  end_column;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_wr;
    logic set_cursor;
    logic begin_place;
    logic walk;
    logic place;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic out_stall;
  } dp_status_t;

endpackage

>>> rtl/ptl_in_if.sv
interface ptl_in_if;
  import ptl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ptl_out_if.sv
interface ptl_out_if;
  import ptl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ptl_cfg_if.sv
interface ptl_cfg_if;
  import ptl_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ptl_datapath.sv
module ptl_datapath #(
  parameter int unsigned TABLE_DEPTH = ptl_pkg::TableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptl_pkg::ctrl_cmd_t            cmd_i,
  output ptl_pkg::dp_status_t           status_o,
  input  ptl_pkg::in_item_t             item_i,
  input  logic                          cfg_valid_i,
  input  logic [ptl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptl_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ptl_pkg::out_item_t            out_item_o
);
  import ptl_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Width table
  logic [7:0] table_mem [TABLE_DEPTH];
  logic [7:0] rd_data_q;

  // Configuration
  logic [7:0] first_sym_q;
  logic [5:0] font_h_q;
  logic [7:0] disp_w_q;

  // Cursor state
  logic [7:0] cur_x_q, cur_y_q, color_q;

  // Walk control
  logic [7:0] cnt_q;
  logic       issued_all_q;
  logic       pend_q, pend_last_q, pend_ok_q;
  logic       below_q;
  logic [7:0] diff_q;

  // Walk payload
  logic [15:0] acc_q;
  logic [7:0]  width_q;

  // Result register
  logic      out_valid_q;
  out_item_t out_item_q;

  logic       load_in_range, cnt_in_range;
  logic [7:0] pend_val;

  assign load_in_range = {1'b0, item_i.entry_index} < 9'(TABLE_DEPTH);
  assign cnt_in_range  = {1'b0, cnt_q} < 9'(TABLE_DEPTH);
  assign pend_val      = pend_ok_q ? rd_data_q : 8'd0;

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_in_range) begin
      table_mem[item_i.entry_index[IdxW-1:0]] <= item_i.entry_width;
    end
    rd_data_q <= table_mem[cnt_q[IdxW-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sym_q <= FirstSymbolRst;
      font_h_q    <= FontHeightRst;
      disp_w_q    <= DisplayWidthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_SYMBOL:  first_sym_q <= cfg_data_i[7:0];
        CFG_FONT_HEIGHT:   font_h_q    <= cfg_data_i[5:0];
        CFG_DISPLAY_WIDTH: disp_w_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Cursor update and wrap tests for a place
  logic [8:0] reach1;
  logic       wrap1, wrap2;
  logic [7:0] step_y, x1, y1, x2, x3, y3, end_col;

  always_comb begin
    step_y  = 8'({2'b00, font_h_q}) + 8'd1;
    reach1  = {1'b0, cur_x_q} + {1'b0, width_q};
    wrap1   = reach1 > {1'b0, disp_w_q};
    x1      = wrap1 ? 8'd0 : cur_x_q;
    y1      = wrap1 ? cur_y_q + step_y : cur_y_q;
    x2      = x1 + width_q + 8'd1;
    wrap2   = x2 > disp_w_q;
    x3      = wrap2 ? 8'd0 : x2;
    y3      = wrap2 ? y1 + step_y : y1;
    end_col = x3 - 8'd1;
  end

  // Cursor, walk control and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      color_q      <= '0;
      cnt_q        <= '0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      pend_ok_q    <= 1'b0;
      below_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.set_cursor) begin
        cur_x_q <= item_i.start_x;
        cur_y_q <= item_i.start_y;
        color_q <= item_i.draw_color;
      end else if (cmd_i.place) begin
        cur_x_q <= x3;
        cur_y_q <= y3;
      end

      if (cmd_i.begin_place) begin
        cnt_q        <= '0;
        issued_all_q <= 1'b0;
        pend_q       <= 1'b0;
        below_q      <= item_i.symbol < first_sym_q;
      end else if (cmd_i.walk) begin
        // one table read issued per cycle, indexes 0 up to diff
        if (!issued_all_q && !below_q) begin
          pend_q       <= 1'b1;
          pend_last_q  <= cnt_q == diff_q;
          pend_ok_q    <= cnt_in_range;
          issued_all_q <= cnt_q == diff_q;
          cnt_q        <= cnt_q + 8'd1;
        end else begin
          pend_q <= 1'b0;
        end
      end

      if (cmd_i.place) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Offset sum, glyph width and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_place) begin
      diff_q  <= item_i.symbol - first_sym_q;
      acc_q   <= '0;
      width_q <= '0;
    end else if (cmd_i.walk && pend_q && !below_q) begin
      if (pend_last_q) begin
        width_q <= pend_val;
      end else begin
        acc_q <= acc_q + {8'd0, pend_val};
      end
    end

    if (cmd_i.place) begin
      out_item_q.glyph_x      <= x1;
      out_item_q.glyph_y      <= y1;
      out_item_q.glyph_offset <= acc_q;
      out_item_q.glyph_width  <= width_q;
      out_item_q.color_out    <= color_q;
      out_item_q.end_column   <= end_col;
    end
  end

  assign status_o.walk_done = below_q || (pend_q && pend_last_q);
  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_item_q;

endmodule

>>> rtl/ptl_ctrl.sv
module ptl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_action_i,
  output logic                in_ready_o,
  input  ptl_pkg::dp_status_t status_i,
  output ptl_pkg::ctrl_cmd_t  cmd_o
);
  import ptl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_PLACE
  } state_e;

  state_e state_q;

  // Command decode
  always_comb begin
    cmd_o      = '0;
    in_ready_o = state_q == ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_action_i)
            ACT_LOAD:  cmd_o.load_wr     = 1'b1;
            ACT_START: cmd_o.set_cursor  = 1'b1;
            ACT_PLACE: cmd_o.begin_place = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SUM:   cmd_o.walk  = 1'b1;
      ST_PLACE: cmd_o.place = !status_i.out_stall;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_action_i == ACT_PLACE) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (status_i.walk_done) begin
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if (!status_i.out_stall) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.place |-> !status_i.out_stall)
    else $error("place issued while result word stalled");

  // Commands are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_wr, cmd_o.set_cursor, cmd_o.begin_place, cmd_o.walk, cmd_o.place}))
    else $error("more than one datapath command");

  // No input taken while a character is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.walk && !cmd_o.place)
    else $error("input ready during character work");

  // Walk ends in a place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && status_i.walk_done) |=> cmd_o.place || status_i.out_stall)
    else $error("walk finished without place");

endmodule

>>> rtl/proportional_text_layout_unit.sv
// Proportional-font text layout unit.
// Input channel in_i carries one word per item: load a glyph width into the
// table, start a string (cursor x, y and colour), or place one character.
// Output channel out_o carries one draw command per placed character; loads
// and starts give no output. Configuration words on cfg_i set the first
// symbol, font height and display width; they are always accepted and must
// be written only while the unit is idle.
// Load and start words complete in the cycle they are accepted. A place word
// blocks the next word until its draw command is registered; a symbol below
// the first one skips the walk. After the walk ends, the controller enters
// its place state and the draw command is registered in the output register.
// The walk reads one width table entry per cycle through its read port.
// Reset clears the cursor and colour to zero and loads the register reset
// values; the width table holds no defined contents until loaded.
// While the receiver stalls, the draw command is held in the output
// register; further loads and starts are taken, and a following place
// waits only at its final step.
module proportional_text_layout_unit #(
  parameter int unsigned TABLE_DEPTH = ptl_pkg::TableDepth
) (
  input logic       clk_i,
  input logic       rst_ni,
  ptl_in_if.sink    in_i,
  ptl_out_if.source out_o,
  ptl_cfg_if.sink   cfg_i
);
  import ptl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  ptl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.payload.action),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (in_i.payload),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule
